// ----- hw/rtl/tccw_pkg.sv -----
// text console cell writer: shared types, geometry constants and codes
// used by tccw_ctrl, tccw_dp and text_console_cell_writer_core
// no dependencies
package tccw_pkg;

  localparam int ROWS      = 25;
  localparam int COLS      = 80;
  localparam int CELLS     = ROWS * COLS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int COPY_LAST = (ROWS - 1) * COLS - 1;
  localparam int FILL_BASE = (ROWS - 1) * COLS;

  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int IN_ROW_W    = 5;
  localparam int IN_COL_W    = 7;
  localparam int CELL_DATA_W = ATTR_W + CHAR_W;
  localparam int OUT_ROW_W   = 5;
  localparam int OUT_COL_W   = 7;
  localparam int OUT_POS_W   = 11;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 40;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic clear_cursor;
    logic latch_read;
    logic cnt_load_zero;
    logic cnt_load_row;
    logic copy_step;
    logic fill_step;
    logic fill_reset_attr;
    logic result_load;
  } tccw_cmd_t;

  typedef struct packed {
    op_t  op;
    logic need_scroll;
    logic copy_last;
    logic fill_last;
    logic out_busy;
  } tccw_stat_t;

endpackage

// ----- hw/rtl/tccw_ctrl.sv -----
// text console cell writer: controller state machine
// depends on tccw_pkg; drives tccw_dp through command and status structs
module tccw_ctrl import tccw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tccw_stat_t stat,
  output tccw_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.fill_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_PUT:   state_next = stat.need_scroll ? S_SCROLL : S_DONE;
          OP_READ:  state_next = S_RDWAIT;
          OP_CLEAR: state_next = S_FILL;
          default:  state_next = S_DONE;
        endcase
      end
      S_RDWAIT: state_next = S_DONE;
      S_SCROLL: begin
        if (stat.copy_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_FILL;
      S_FILL: begin
        if (stat.fill_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.fill_step       = 1'b1;
        cmd.fill_reset_attr = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_PUT: begin
            cmd.exec          = 1'b1;
            cmd.cnt_load_zero = stat.need_scroll;
          end
          OP_CLEAR: begin
            cmd.clear_cursor  = 1'b1;
            cmd.cnt_load_zero = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: cmd.latch_read   = 1'b1;
      S_SCROLL: cmd.copy_step    = 1'b1;
      S_DRAIN:  cmd.cnt_load_row = 1'b1;
      S_FILL:   cmd.fill_step    = 1'b1;
      S_DONE:   cmd.result_load  = !stat.out_busy;
      default: begin
      end
    endcase
  end

  // the power-up clearing pass runs once
  a_init_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |=> (state != S_INIT))
    else $error("controller re-entered the clearing pass");

endmodule

// ----- hw/rtl/tccw_dp.sv -----
// text console cell writer: datapath with cell store, cursor, sweep counter
// and result register; depends on tccw_pkg, commanded by tccw_ctrl
module tccw_dp import tccw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  tccw_cmd_t              cmd,
  output tccw_stat_t             stat,
  input  logic [S_TDATA_W-1:0]   in_data,
  input  logic [OP_W-1:0]        in_op,
  input  logic                   cfg_valid,
  input  logic [ATTR_W-1:0]      cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [M_TDATA_W-1:0]   out_data
);

  logic [ATTR_W-1:0]      default_attr;
  logic [ROW_W-1:0]       crs_row;
  logic [COL_W-1:0]       crs_col;

  op_t                    item_op;
  logic [CHAR_W-1:0]      item_char;
  logic                   item_usepos;
  logic [IN_ROW_W-1:0]    item_row;
  logic [IN_COL_W-1:0]    item_col;
  logic [ATTR_W-1:0]      item_attr;

  logic [CELL_W-1:0]      idx;
  logic [CELL_W-1:0]      wr_addr_d;
  logic                   pend;
  logic [CELL_DATA_W-1:0] mem [CELLS];
  logic [CELL_DATA_W-1:0] rd_data;
  logic                   scrolled;
  logic [CELL_DATA_W-1:0] rd_val;

  logic [ATTR_W-1:0]      attr_eff;
  logic [ATTR_W-1:0]      fill_attr;
  logic [CELL_W-1:0]      cur_addr;
  logic [CELL_W-1:0]      item_addr;
  logic                   pos_ok;
  logic [ROW_W:0]         row_t;
  logic [COL_W:0]         col_t;
  logic                   need_scroll;
  logic                   ex_we;
  logic [CELL_W-1:0]      ex_addr;
  logic [CELL_DATA_W-1:0] ex_data;
  logic [ROW_W-1:0]       row_new;
  logic [COL_W-1:0]       col_new;

  logic                   mem_we;
  logic [CELL_W-1:0]      mem_waddr;
  logic [CELL_DATA_W-1:0] mem_wdata;
  logic [CELL_W-1:0]      mem_raddr;

  logic [CELL_W-1:0]              cur_pos;
  logic [ROW_W+OUT_ROW_W-1:0]     row_ext;
  logic [COL_W+OUT_COL_W-1:0]     col_ext;
  logic [CELL_W+OUT_POS_W-1:0]    pos_ext;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= ATTR_RESET;
    end else if (cfg_valid) begin
      default_attr <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op     <= op_t'(in_op);
      item_char   <= in_data[7:0];
      item_usepos <= in_data[8];
      item_row    <= in_data[13:9];
      item_col    <= in_data[20:14];
      item_attr   <= in_data[28:21];
    end
  end

  // put decode
  always_comb begin
    attr_eff  = (item_attr == '0) ? default_attr : item_attr;
    fill_attr = cmd.fill_reset_attr ? ATTR_RESET : default_attr;
    cur_addr  = CELL_W'(crs_row) * CELL_W'(COLS) + CELL_W'(crs_col);
    item_addr = CELL_W'(item_row) * CELL_W'(COLS) + CELL_W'(item_col);
    pos_ok    = (item_row < ROWS) && (item_col < COLS);
    row_t     = {1'b0, crs_row};
    col_t     = {1'b0, crs_col};
    ex_we     = 1'b0;
    ex_addr   = cur_addr;
    ex_data   = {attr_eff, item_char};
    priority if (item_char == CH_NEWLINE) begin
      row_t = row_t + 1'b1;
      col_t = '0;
    end else if (item_char == CH_BACKSPACE) begin
      if (crs_col != '0) begin
        col_t   = col_t - 1'b1;
        ex_we   = 1'b1;
        ex_addr = cur_addr - 1'b1;
        ex_data = {attr_eff, CH_BLANK};
      end
    end else if (item_usepos) begin
      if (pos_ok) begin
        ex_we   = 1'b1;
        ex_addr = item_addr;
      end
    end else begin
      ex_we = 1'b1;
      col_t = col_t + 1'b1;
    end
    if (col_t >= COLS) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    need_scroll = (row_t >= ROWS);
    row_new     = need_scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];
    col_new     = col_t[COL_W-1:0];
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {fill_attr, CH_BLANK};
    priority if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_d;
      mem_wdata = rd_data;
    end else if (cmd.fill_step) begin
      mem_we = 1'b1;
    end else if (cmd.exec) begin
      mem_we    = ex_we;
      mem_waddr = ex_addr;
      mem_wdata = ex_data;
    end
    mem_raddr = cmd.copy_step ? (idx + CELL_W'(COLS)) : item_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // sweep counter and copy pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.copy_step;
      priority if (cmd.cnt_load_zero) begin
        idx <= '0;
      end else if (cmd.cnt_load_row) begin
        idx <= CELL_W'(FILL_BASE);
      end else if (cmd.copy_step || cmd.fill_step) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_d <= idx;
  end

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      crs_row <= '0;
      crs_col <= '0;
    end else if (cmd.clear_cursor) begin
      crs_row <= '0;
      crs_col <= '0;
    end else if (cmd.exec) begin
      crs_row <= row_new;
      crs_col <= col_new;
    end
  end

  // per-item result fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scrolled <= 1'b0;
      rd_val   <= '0;
    end else begin
      if (cmd.exec) scrolled <= need_scroll;
      if (cmd.latch_read) rd_val <= pos_ok ? rd_data : '0;
    end
  end

  // result register
  always_comb begin
    cur_pos = CELL_W'(crs_row) * CELL_W'(COLS) + CELL_W'(crs_col);
    row_ext = {{OUT_ROW_W{1'b0}}, crs_row};
    col_ext = {{OUT_COL_W{1'b0}}, crs_col};
    pos_ext = {{OUT_POS_W{1'b0}}, cur_pos};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_data <= {scrolled, pos_ext[OUT_POS_W-1:0], col_ext[OUT_COL_W-1:0],
                   row_ext[OUT_ROW_W-1:0], rd_val};
    end
  end

  always_comb begin
    stat.op          = item_op;
    stat.need_scroll = need_scroll;
    stat.copy_last   = (idx == CELL_W'(COPY_LAST));
    stat.fill_last   = (idx == CELL_W'(CELLS - 1));
    stat.out_busy    = out_valid && !out_ready;
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (crs_row < ROWS) && (crs_col < COLS))
    else $error("cursor outside the screen");

  a_copy_no_fill: assert property (@(posedge clk) disable iff (rst)
    pend |-> !(cmd.fill_step || cmd.exec))
    else $error("scroll copy write collides with another write");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> !(out_valid && !out_ready))
    else $error("result register overwritten while stalled");

endmodule

// ----- hw/rtl/text_console_cell_writer_core.sv -----
// Text console cell writer: an 80x25 store of 16-bit cells (attribute above
// character) and a cursor. One item in, one result out.
// Slave stream carries the request (tuser = op, tdata = fields), master
// stream carries the result; cfg_valid/cfg_data write the default attribute.
// A put that does not scroll runs through the execute and done states, and
// its result is loaded in the done state; a read adds a wait state for the
// cell read. A put that runs off the last row scrolls: one cell per cycle
// is copied up through the cell store, a drain state writes the last copied
// cell, then COLS cells blank the last row. Clear sweeps all ROWS*COLS cells.
// A new request is taken only in the idle state, after the last result is
// loaded. Every result reports the cursor.
// After reset a clearing pass of ROWS*COLS = 2000 cells fills the store with
// blanks at attribute 0x0F; s_axis_tready stays low meanwhile, while
// configuration writes are taken at any time (cfg_ready is always high).
// The result sits in an output register: the next request is accepted while
// it waits; if the receiver stalls the block holds its next result, with
// s_axis_tready low, until the register frees.
// depends on tccw_pkg, tccw_ctrl, tccw_dp
module text_console_cell_writer_core import tccw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // char_code[7:0], use_position[8], cell_row[13:9], cell_col[20:14],
  // attribute[28:21], zero fill[31:29]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // read_cell[15:0], cursor_row_out[20:16], cursor_col_out[27:21],
  // cursor_pos[38:28], scrolled[39]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ATTR_W-1:0]    cfg_data
);

  tccw_cmd_t  cmd;
  tccw_stat_t stat;

  assign cfg_ready = 1'b1;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tccw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_op     (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule
